@@ rtl/lgs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants of the life grid generation step core.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int GridRowsDefault = 128;
  localparam int GridColsDefault = 256;

  localparam int ActionW   = 2;
  localparam int RowFieldW = 7;
  localparam int ColFieldW = 8;

  localparam int SurviveCount = 2;
  localparam int BirthCount   = 3;

  typedef enum logic [ActionW-1:0] {
    ACT_SET     = 2'd0,
    ACT_ADVANCE = 2'd1,
    ACT_READ    = 2'd2
  } lgs_action_e;

  typedef struct packed {
    logic clear;
    logic shift;
  } lgs_cell_ctrl_t;

endpackage

@@ rtl/lgs_row_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_row_mem
// Row-wide grid memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lgs_row_mem #(
  parameter int Depth = 128,
  parameter int Width = 256
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/lgs_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgs_cell
// One grid column: a three-row window that shifts down when shift is set and
// applies the B3/S23 rule using the windows of the two neighboring columns.
// ----------------------------------------------------------------------------
module lgs_cell
  import lgs_pkg::*;
(
  input  logic           clk_i,
  input  lgs_cell_ctrl_t ctrl_i,
  input  logic           row_bit_i,
  input  logic [2:0]     west_i,
  input  logic [2:0]     east_i,
  output logic [2:0]     col_o,
  output logic           next_o
);

  logic       above_q, cur_q, below_q;
  logic       above_d, cur_d, below_d;
  logic [3:0] count;

  always_comb begin
    above_d = above_q;
    cur_d   = cur_q;
    below_d = below_q;
    if (ctrl_i.clear) begin
      above_d = 1'b0;
      cur_d   = 1'b0;
      below_d = 1'b0;
    end else if (ctrl_i.shift) begin
      above_d = cur_q;
      cur_d   = below_q;
      below_d = row_bit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    above_q <= above_d;
    cur_q   <= cur_d;
    below_q <= below_d;
  end

  assign col_o = {above_q, cur_q, below_q};

  assign count = {3'b0, west_i[0]} + {3'b0, west_i[1]} + {3'b0, west_i[2]}
               + {3'b0, east_i[0]} + {3'b0, east_i[1]} + {3'b0, east_i[2]}
               + {3'b0, above_q} + {3'b0, below_q};

  assign next_o = (count == 4'(BirthCount)) || (cur_q && (count == 4'(SurviveCount)));

endmodule

@@ rtl/life_grid_generation_step_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_generation_step_core
// B3/S23 cellular grid with set, advance and read transactions.
// ----------------------------------------------------------------------------
// The grid is stored as GRID_ROWS rows of GRID_COLS bits. After reset the
// core clears the memory one row per cycle in state ST_CLEAR before it
// takes its first input transaction. Set, read and unused actions pass
// through states ST_OP and ST_FIN to the result register. An advance
// streams the rows through a chain of GRID_COLS column cells, one row read
// and one row written back per cycle in state ST_ADV, then goes through
// ST_FIN to its result. One transaction at a time: the core accepts the
// next one as soon as the previous result sits in the output register.
// ----------------------------------------------------------------------------
module life_grid_generation_step_core
  import lgs_pkg::*;
#(
  parameter int GRID_ROWS = GridRowsDefault,
  parameter int GRID_COLS = GridColsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // row [6:0], col [14:7], zero [15]
  input  logic [1:0]  s_axis_tuser,  // action [1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // cell_alive [0], zero [7:1]
);

  localparam int RowAw = $clog2(GRID_ROWS);
  localparam int ColAw = $clog2(GRID_COLS);
  localparam int SwpW  = $clog2(GRID_ROWS + 3);

  localparam logic [SwpW-1:0] SwpRows    = SwpW'(GRID_ROWS);
  localparam logic [SwpW-1:0] SwpRowLast = SwpW'(GRID_ROWS - 1);
  localparam logic [SwpW-1:0] SwpLag     = SwpW'(3);
  localparam logic [SwpW-1:0] SwpLast    = SwpW'(GRID_ROWS + 2);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_OP    = 3'd2;
  localparam logic [2:0] ST_ADV   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [SwpW-1:0]   swp_q, swp_d;
  logic [SwpW-1:0]   swp_wr;
  lgs_action_e       op_act_q, op_act_d;
  logic [RowAw-1:0]  op_row_q, op_row_d;
  logic [ColAw-1:0]  op_col_q, op_col_d;
  logic              op_in_q, op_in_d;
  logic              out_valid_q, out_valid_d;
  logic              out_alive_q, out_alive_d;

  logic [RowFieldW-1:0] in_row;
  logic [ColFieldW-1:0] in_col;
  logic                 in_inside;
  logic                 in_accept;

  logic                 rd_en, wr_en;
  logic [RowAw-1:0]     rd_addr, wr_addr;
  logic [GRID_COLS-1:0] rd_data, wr_data, next_row;
  logic                 row_in_valid;
  lgs_cell_ctrl_t       cell_ctrl;
  logic [2:0]           col_bits [GRID_COLS];

  assign in_row    = s_axis_tdata[6:0];
  assign in_col    = s_axis_tdata[14:7];
  assign in_inside = (32'(in_row) < 32'(GRID_ROWS)) && (32'(in_col) < 32'(GRID_COLS));
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign swp_wr    = swp_q - SwpLag;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_alive_q};

  always_comb begin
    state_d      = state_q;
    swp_d        = swp_q;
    op_act_d     = op_act_q;
    op_row_d     = op_row_q;
    op_col_d     = op_col_q;
    op_in_d      = op_in_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_alive_d  = out_alive_q;
    rd_en        = 1'b0;
    rd_addr      = swp_q[RowAw-1:0];
    wr_en        = 1'b0;
    wr_addr      = swp_q[RowAw-1:0];
    wr_data      = '0;
    row_in_valid = 1'b0;
    cell_ctrl    = '0;
    unique case (state_q)
      ST_CLEAR: begin
        wr_en = 1'b1;
        if (swp_q == SwpRowLast) begin
          swp_d   = '0;
          state_d = ST_IDLE;
        end else begin
          swp_d = swp_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          op_act_d = lgs_action_e'(s_axis_tuser);
          op_row_d = RowAw'(in_row);
          op_col_d = ColAw'(in_col);
          op_in_d  = in_inside;
          rd_addr  = RowAw'(in_row);
          if (s_axis_tuser == ACT_ADVANCE) begin
            swp_d           = '0;
            cell_ctrl.clear = 1'b1;
            state_d         = ST_ADV;
          end else begin
            rd_en   = in_inside;
            state_d = ST_OP;
          end
        end
      end
      ST_OP: begin
        wr_addr = op_row_q;
        wr_data = rd_data | (GRID_COLS'(1) << op_col_q);
        wr_en   = (op_act_q == ACT_SET) && op_in_q;
        state_d = ST_FIN;
      end
      ST_ADV: begin
        rd_en           = (swp_q < SwpRows);
        cell_ctrl.shift = (swp_q != '0);
        row_in_valid    = (swp_q <= SwpRows);
        wr_en           = (swp_q >= SwpLag);
        wr_addr         = swp_wr[RowAw-1:0];
        wr_data         = next_row;
        if (swp_q == SwpLast) begin
          swp_d   = '0;
          state_d = ST_FIN;
        end else begin
          swp_d = swp_q + 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_alive_d = (op_act_q == ACT_READ) && op_in_q && rd_data[op_col_q];
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      swp_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      swp_q       <= swp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_act_q    <= op_act_d;
    op_row_q    <= op_row_d;
    op_col_q    <= op_col_d;
    op_in_q     <= op_in_d;
    out_alive_q <= out_alive_d;
  end

  lgs_row_mem #(
    .Depth (GRID_ROWS),
    .Width (GRID_COLS)
  ) u_row_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  for (genvar c = 0; c < GRID_COLS; c++) begin : g_cell
    logic [2:0] west, east;
    if (c == 0) begin : g_west_edge
      assign west = 3'b0;
    end else begin : g_west
      assign west = col_bits[c-1];
    end
    if (c == GRID_COLS - 1) begin : g_east_edge
      assign east = 3'b0;
    end else begin : g_east
      assign east = col_bits[c+1];
    end
    lgs_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cell_ctrl),
      .row_bit_i (row_in_valid && rd_data[c]),
      .west_i    (west),
      .east_i    (east),
      .col_o     (col_bits[c]),
      .next_o    (next_row[c])
    );
  end

endmodule
